// File: rtl/core/i2crts_pkg.sv
// Package: shared types and codes of the I2C register transaction sequencer.
`timescale 1ns / 1ps

package i2crts_pkg;

    localparam logic [1:0] KIND_COMMAND  = 2'd0;
    localparam logic [1:0] KIND_BUS_FREE = 2'd1;
    localparam logic [1:0] KIND_XFER     = 2'd2;

    localparam logic [1:0] EV_COMMAND  = 2'd0;
    localparam logic [1:0] EV_BUS_FREE = 2'd1;
    localparam logic [1:0] EV_XFER     = 2'd2;

    localparam logic [2:0] ACT_START   = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_RESTART = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic       op;
        logic [7:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic [7:0] read_length;
        logic       byte_acked;
        logic [7:0] received_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       done_res;
        logic       success;
    } out_word_t;

    typedef struct packed {
        logic [1:0] ev;
        logic       op;
        logic [7:0] device_address;
        logic [7:0] register_index;
        logic [7:0] write_value;
        logic [7:0] read_length;
        logic       byte_acked;
        logic [7:0] received_byte;
    } event_t;

endpackage

// File: rtl/core/i2crts_front.sv
// Front end: accepts input words, drops undefined kinds, queues events.
`timescale 1ns / 1ps

module i2crts_front
(
    input  logic               in_valid,
    output logic               in_ready,
    input  i2crts_pkg::in_word_t in_word,
    output logic               q_push,
    output i2crts_pkg::event_t q_word,
    input  logic               q_ready
);
    import i2crts_pkg::*;

    logic known_kind;

    assign known_kind = (in_word.kind == KIND_COMMAND) || (in_word.kind == KIND_BUS_FREE)
                     || (in_word.kind == KIND_XFER);

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready && known_kind;

    always_comb
    begin
        q_word.ev = EV_XFER;
        unique case (in_word.kind)
            KIND_COMMAND:  q_word.ev = EV_COMMAND;
            KIND_BUS_FREE: q_word.ev = EV_BUS_FREE;
            default:       q_word.ev = EV_XFER;
        endcase
        q_word.op             = in_word.op;
        q_word.device_address = in_word.device_address;
        q_word.register_index = in_word.register_index;
        q_word.write_value    = in_word.write_value;
        q_word.read_length    = in_word.read_length;
        q_word.byte_acked     = in_word.byte_acked;
        q_word.received_byte  = in_word.received_byte;
    end

endmodule

// File: rtl/core/i2crts_queue.sv
// Event queue between front end and sequencer back end.
`timescale 1ns / 1ps

module i2crts_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               push_ready,
    input  i2crts_pkg::event_t push_word,
    output logic               pop_valid,
    input  logic               pop,
    output i2crts_pkg::event_t pop_word
);
    import i2crts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    event_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// File: rtl/core/i2crts_back.sv
// Back end: transaction state machine and registered output word.
`timescale 1ns / 1ps

module i2crts_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  i2crts_pkg::event_t    q_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2crts_pkg::out_word_t out_word
);
    import i2crts_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_WAITBUS = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_REG     = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;
    localparam logic [2:0] PH_RADDR   = 3'd5;
    localparam logic [2:0] PH_RECV    = 3'd6;

    logic [2:0] phase_reg, phase_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] regidx_reg, regidx_next;
    logic [7:0] value_reg, value_next;
    logic [7:0] left_reg, left_next;
    logic       out_valid_reg, out_valid_next;
    out_word_t  out_word_reg;
    out_word_t  res;
    logic       has_res;
    logic [7:0] left_dec;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign left_dec  = left_reg - 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        regidx_next  = regidx_reg;
        value_next   = value_reg;
        left_next    = left_reg;
        has_res      = 1'b0;
        res          = '0;
        res.action   = ACT_STOP;
        unique case (q_word.ev)
            EV_COMMAND:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_read_next = q_word.op;
                    addr_next    = q_word.device_address;
                    regidx_next  = q_word.register_index;
                    value_next   = q_word.write_value;
                    left_next    = q_word.read_length;
                    phase_next   = PH_WAITBUS;
                end
            end
            EV_BUS_FREE:
            begin
                if (phase_reg == PH_WAITBUS)
                begin
                    phase_next  = PH_ADDR;
                    has_res     = 1'b1;
                    res.action  = ACT_START;
                    res.tx_byte = addr_reg;
                end
            end
            EV_XFER:
            begin
                unique case (phase_reg)
                    PH_ADDR:
                    begin
                        has_res = 1'b1;
                        if (!q_word.byte_acked)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            phase_next  = PH_REG;
                            res.action  = ACT_SEND;
                            res.tx_byte = regidx_reg;
                        end
                    end
                    PH_REG:
                    begin
                        has_res = 1'b1;
                        if (!q_word.byte_acked)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else if (is_read_reg)
                        begin
                            phase_next  = PH_RADDR;
                            res.action  = ACT_RESTART;
                            res.tx_byte = addr_reg + 8'd1;
                        end
                        else
                        begin
                            phase_next  = PH_VALUE;
                            res.action  = ACT_SEND;
                            res.tx_byte = value_reg;
                        end
                    end
                    PH_VALUE:
                    begin
                        has_res      = 1'b1;
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                        res.success  = q_word.byte_acked;
                    end
                    PH_RADDR:
                    begin
                        has_res = 1'b1;
                        if (!q_word.byte_acked || (left_reg == 8'd0))
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RECV;
                            res.action = (left_reg == 8'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                        end
                    end
                    PH_RECV:
                    begin
                        has_res        = 1'b1;
                        left_next      = left_dec;
                        res.data_byte  = q_word.received_byte;
                        res.data_valid = 1'b1;
                        if (left_dec == 8'd0)
                        begin
                            phase_next   = PH_IDLE;
                            res.done_res = 1'b1;
                            res.success  = 1'b1;
                        end
                        else
                        begin
                            res.action = (left_dec == 8'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                        end
                    end
                    default:
                    begin
                        has_res = 1'b0;
                    end
                endcase
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (q_pop && has_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            is_read_reg   <= 1'b0;
            addr_reg      <= '0;
            regidx_reg    <= '0;
            value_reg     <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg   <= phase_next;
                is_read_reg <= is_read_next;
                addr_reg    <= addr_next;
                regidx_reg  <= regidx_next;
                value_reg   <= value_next;
                left_reg    <= left_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && has_res)
        begin
            out_word_reg <= res;
        end
    end

endmodule

// File: rtl/core/i2crts_top.sv
// Top level of the I2C register transaction sequencer.
`timescale 1ns / 1ps

// I2C master register transaction sequencer. Input words carry either a
// register command or a bus engine event (bus free, byte transfer done);
// each event yields at most one output word naming the next bus action,
// any received byte, and the final status. Words are taken at one per
// cycle while the output side is not stalled: a small event queue of
// QUEUE_DEPTH entries feeds the sequencer state machine, which handles
// one event per cycle, when not stalled, into a registered output word.
// An input word is written into the queue and its result then into the
// output register; while the output side stalls, up to QUEUE_DEPTH
// further input words are still taken.
module i2c_register_transaction_sequencer_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  i2crts_pkg::in_word_t  in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2crts_pkg::out_word_t out_word
);
    import i2crts_pkg::*;

    logic   push, push_ready, pop_valid, pop;
    event_t push_word, pop_word;

    i2crts_front u_front
    (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .q_push   (push),
        .q_word   (push_word),
        .q_ready  (push_ready)
    );

    i2crts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_word   (pop_word)
    );

    i2crts_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_pop     (pop),
        .q_word    (pop_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

// File: dv/tb.sv
// Testbench for the I2C register transaction sequencer: random commands and bus events, checked word by word.
`timescale 1ns / 1ps

module tb;

    import i2crts_pkg::*;

    localparam logic [1:0]  KIND_RESERVED = 2'd3;
    localparam int unsigned N_ITEMS       = 1650;
    localparam int unsigned TAIL_ITEMS    = 150;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned HOLD_FROM     = 800;
    localparam int unsigned HOLD_TO       = 1100;
    localparam int unsigned MAX_REPORTS   = 40;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_BUS,
        PH_ADDR,
        PH_REG,
        PH_VALUE,
        PH_RADDR,
        PH_RECV
    } seq_phase_e;

    typedef struct {
        in_word_t    word;
        int unsigned gap;
        bit          drain;
    } bus_event_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    bus_event_t  event_q[$];
    out_word_t   bus_actions_due[$];
    int unsigned actions_due_cnt = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;
    int unsigned gap_cnt;
    int unsigned stall_cnt;
    bit          send_now;
    bit          tail_part = 1'b0;
    bit          long_hold = 1'b0;
    bit          idle_mode = 1'b0;
    bit          stall_mode = 1'b0;
    bit          drain_next = 1'b0;
    bit          noise_on = 1'b0;
    out_word_t   got_action;
    out_word_t   want_action;

    seq_phase_e  seq_phase;
    logic        cur_is_read;
    logic [7:0]  cur_address;
    logic [7:0]  cur_register;
    logic [7:0]  cur_value;
    logic [7:0]  cur_bytes_left;

    i2c_register_transaction_sequencer_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit next_bus_action(input in_word_t w, output out_word_t act);
        bit hit;
        hit = 1'b0;
        act = '0;
        if (w.kind == KIND_COMMAND)
        begin
            if (seq_phase == PH_IDLE)
            begin
                cur_is_read    = w.op;
                cur_address    = w.device_address;
                cur_register   = w.register_index;
                cur_value      = w.write_value;
                cur_bytes_left = w.read_length;
                seq_phase      = PH_WAIT_BUS;
            end
        end
        else if (w.kind == KIND_BUS_FREE)
        begin
            if (seq_phase == PH_WAIT_BUS)
            begin
                hit         = 1'b1;
                seq_phase   = PH_ADDR;
                act.action  = ACT_START;
                act.tx_byte = cur_address;
            end
        end
        else if (w.kind == KIND_XFER)
        begin
            hit = 1'b1;
            case (seq_phase)
                PH_ADDR:
                begin
                    if (!w.byte_acked)
                    begin
                        act.action   = ACT_STOP;
                        act.done_res = 1'b1;
                        seq_phase    = PH_IDLE;
                    end
                    else
                    begin
                        act.action  = ACT_SEND;
                        act.tx_byte = cur_register;
                        seq_phase   = PH_REG;
                    end
                end
                PH_REG:
                begin
                    if (!w.byte_acked)
                    begin
                        act.action   = ACT_STOP;
                        act.done_res = 1'b1;
                        seq_phase    = PH_IDLE;
                    end
                    else if (cur_is_read)
                    begin
                        act.action  = ACT_RESTART;
                        act.tx_byte = cur_address + 8'd1;
                        seq_phase   = PH_RADDR;
                    end
                    else
                    begin
                        act.action  = ACT_SEND;
                        act.tx_byte = cur_value;
                        seq_phase   = PH_VALUE;
                    end
                end
                PH_VALUE:
                begin
                    act.action   = ACT_STOP;
                    act.done_res = 1'b1;
                    act.success  = w.byte_acked;
                    seq_phase    = PH_IDLE;
                end
                PH_RADDR:
                begin
                    if (!w.byte_acked || cur_bytes_left == 8'd0)
                    begin
                        act.action   = ACT_STOP;
                        act.done_res = 1'b1;
                        seq_phase    = PH_IDLE;
                    end
                    else
                    begin
                        act.action = (cur_bytes_left == 8'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                        seq_phase  = PH_RECV;
                    end
                end
                PH_RECV:
                begin
                    cur_bytes_left = cur_bytes_left - 8'd1;
                    act.data_byte  = w.received_byte;
                    act.data_valid = 1'b1;
                    if (cur_bytes_left == 8'd0)
                    begin
                        act.action   = ACT_STOP;
                        act.done_res = 1'b1;
                        act.success  = 1'b1;
                        seq_phase    = PH_IDLE;
                    end
                    else
                    begin
                        act.action = (cur_bytes_left == 8'd1) ? ACT_RX_NACK : ACT_RX_ACK;
                    end
                end
                default:
                    hit = 1'b0;
            endcase
        end
        return hit;
    endfunction

    function automatic in_word_t rand_word(input logic [1:0] kind);
        in_word_t w;
        w.kind           = kind;
        w.op             = 1'($urandom_range(0, 1));
        w.device_address = 8'($urandom_range(0, 255));
        w.register_index = 8'($urandom_range(0, 255));
        w.write_value    = 8'($urandom_range(0, 255));
        w.read_length    = 8'($urandom_range(0, 255));
        w.byte_acked     = 1'($urandom_range(0, 1));
        w.received_byte  = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic push_word(input in_word_t w);
        bus_event_t ev;
        if ($urandom_range(0, 49) == 0)
            idle_mode = !idle_mode;
        ev.word  = w;
        ev.gap   = (idle_mode && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
        ev.drain = drain_next;
        drain_next = 1'b0;
        event_q.push_back(ev);
    endtask

    task automatic push_event(input logic [1:0] kind, input logic ack, input logic [7:0] rx);
        in_word_t w;
        if (noise_on && $urandom_range(0, 39) == 0)
            push_word(rand_word(2'($urandom_range(KIND_COMMAND, KIND_RESERVED))));
        w               = rand_word(kind);
        w.byte_acked    = ack;
        w.received_byte = rx;
        push_word(w);
    endtask

    task automatic push_cmd(input logic op, input logic [7:0] addr, input logic [7:0] regi,
                            input logic [7:0] value, input logic [7:0] len);
        in_word_t w;
        w                = rand_word(KIND_COMMAND);
        w.op             = op;
        w.device_address = addr;
        w.register_index = regi;
        w.write_value    = value;
        w.read_length    = len;
        push_word(w);
    endtask

    // well-formed transaction; now and then cut short
    task automatic push_transaction();
        bit          rd;
        bit          ack;
        logic [7:0]  len;
        int unsigned pick;
        int unsigned budget;
        rd   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        len  = (pick < 6) ? 8'd0 :
               (pick < 7) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 5));
        budget = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 6) : 1000;
        push_cmd(rd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), len);
        if (budget == 0)
            return;
        push_event(KIND_BUS_FREE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        for (int i = 0; i < 3 + (rd ? int'(len) : 0); i++)
        begin
            if (i + 1 >= budget)
                return;
            ack = (i >= 3) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
            push_event(KIND_XFER, ack, 8'($urandom_range(0, 255)));
            if (i < 3 && !ack)
                return;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        int unsigned drains;
        drains = 0;

        push_event(KIND_XFER, 1'b1, 8'hA5);
        push_event(KIND_RESERVED, 1'b1, 8'h00);
        push_cmd(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_cmd(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_BUS_FREE, 1'b1, 8'h00);
        push_event(KIND_BUS_FREE, 1'b0, 8'hFF);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_cmd(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        push_event(KIND_BUS_FREE, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b0, 8'h00);
        push_cmd(1'b1, 8'hFF, 8'h5A, 8'h00, 8'h00);
        push_event(KIND_BUS_FREE, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_cmd(1'b1, 8'h00, 8'hA5, 8'h00, 8'h02);
        push_event(KIND_BUS_FREE, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b1, 8'h00);
        push_event(KIND_XFER, 1'b0, 8'hFF);
        push_event(KIND_XFER, 1'b1, 8'h00);

        noise_on = 1'b1;
        while (event_q.size() < N_ITEMS)
        begin
            if (drains < 2 && event_q.size() >= (drains == 0 ? 1000 : 1400))
            begin
                drain_next = 1'b1;
                drains++;
            end
            if ($urandom_range(0, 9) == 0)
                push_word(rand_word(2'($urandom_range(KIND_COMMAND, KIND_RESERVED))));
            else
                push_transaction();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (event_q.size() != 0 || in_valid)
            @(posedge clk);
        while (bus_actions_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (bus_actions_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, bus_actions_due.size());
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_word   <= '0;
            tail_part <= 1'b0;
            gap_cnt   = 0;
        end
        else
        begin
            tail_part <= (event_q.size() < TAIL_ITEMS);
            if (!in_valid || in_ready)
            begin
                send_now = 1'b0;
                if (event_q.size() != 0)
                begin
                    if (event_q[0].drain && (in_valid || actions_due_cnt != 0))
                        send_now = 1'b0;
                    else if (!tail_part && gap_cnt < event_q[0].gap)
                        gap_cnt++;
                    else
                        send_now = 1'b1;
                end
                if (send_now)
                begin
                    in_word <= event_q[0].word;
                    void'(event_q.pop_front());
                    gap_cnt = 0;
                end
                in_valid <= send_now;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready       <= 1'b0;
            actions_due_cnt <= 0;
            stall_cnt      = 0;
            seq_phase      = PH_IDLE;
            cur_is_read    = 1'b0;
            cur_address    = 8'd0;
            cur_register   = 8'd0;
            cur_value      = 8'd0;
            cur_bytes_left = 8'd0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (bus_actions_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected word, expected none, actual %p",
                                 $time, out_word);
                end
                else
                begin
                    want_action = bus_actions_due.pop_front();
                    check_field("action", 8'(want_action.action), 8'(out_word.action));
                    check_field("tx_byte", want_action.tx_byte, out_word.tx_byte);
                    check_field("data_byte", want_action.data_byte, out_word.data_byte);
                    check_field("data_valid", 8'(want_action.data_valid),
                                8'(out_word.data_valid));
                    check_field("done_res", 8'(want_action.done_res), 8'(out_word.done_res));
                    check_field("success", 8'(want_action.success), 8'(out_word.success));
                end
            end
            if (in_valid && in_ready)
            begin
                if (next_bus_action(in_word, got_action))
                    bus_actions_due.push_back(got_action);
            end
            actions_due_cnt <= bus_actions_due.size();

            if ($urandom_range(0, 63) == 0)
                stall_mode = !stall_mode;
            if (stall_cnt != 0)
                stall_cnt--;
            else if (stall_mode && !tail_part && $urandom_range(0, 5) == 0)
                stall_cnt = $urandom_range(1, 13);
            out_ready <= !long_hold && stall_cnt == 0;
        end
    end

    // cycle count, long output hold-off, timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        long_hold <= (cycle_cnt >= HOLD_FROM) && (cycle_cnt < HOLD_TO);
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/core/i2crts_pkg.sv
rtl/core/i2crts_front.sv
rtl/core/i2crts_queue.sv
rtl/core/i2crts_back.sv
rtl/core/i2crts_top.sv
dv/tb.sv
